// File: design/bmoc_pkg.sv
// Shared types, widths and constants for the 3x3 binary morphology filter.
// Used by bmoc_stage and by the top level binary_morphology_3x3_open_close.
`default_nettype none

package bmoc_pkg;

    // Pixel format
    localparam int unsigned PIXEL_BITS = 8;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = '1;

    // Line length limit used as the default of the top-level parameter
    localparam int unsigned DEF_MAX_WIDTH = 1024;

    // Register field widths
    localparam int unsigned WIDTH_REG_W  = 11;
    localparam int unsigned HEIGHT_W     = 12;
    localparam int unsigned MODE_W       = 2;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 12;

    // Row counters run a few rows past the last image row while draining.
    localparam int unsigned ROW_W = HEIGHT_W + 1;

    // Number of filter stages in the chain
    localparam int unsigned NUM_STAGES = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE      = 2'd2;

    // Operating modes
    localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHAIN  = 2'd2;

    // Reset values of the registers
    localparam logic [WIDTH_REG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [HEIGHT_W-1:0]    RST_FRAME_HEIGHT = 12'd480;
    localparam logic [MODE_W-1:0]      RST_OP_MODE      = MODE_CHAIN;

    // Status of one filter stage, seen by the top-level sequencing logic.
    typedef struct packed {
        logic at_origin;  // next item goes to row 0, column 0
        logic filling;    // the next step produces no window yet
        logic drain;      // the window of the next step lies below the image
        logic last;       // the window of the next step is the frame's last pixel
    } t_stage_stat;

    // True when a pixel triggers the operation (0 for erosion, full scale for dilation).
    function automatic logic pix_hit(input logic [PIXEL_BITS-1:0] pix, input logic dilate);
        pix_hit = dilate ? (pix == PIX_MAX) : (pix == '0);
    endfunction

endpackage

`default_nettype wire

// File: design/bmoc_stage.sv
// One 3x3 erosion/dilation stage: line memory, window registers and position counters.
// Depends on bmoc_pkg.
`default_nettype none

module bmoc_stage import bmoc_pkg::*; #(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int unsigned COL_W = $clog2(MAX_WIDTH),
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_clear,
    input  wire                   i_step,
    input  wire                   i_dilate,
    input  wire  [WW-1:0]         i_width,
    input  wire  [HEIGHT_W-1:0]   i_height,
    input  wire  [PIXEL_BITS-1:0] i_pixel,
    output logic [PIXEL_BITS-1:0] o_pixel,
    output t_stage_stat           o_stat
);

    logic [ROW_W-1:0]        r_row, n_row;
    logic [COL_W-1:0]        r_col, n_col;
    logic [WW-1:0]           col_ext, col_inc;
    logic [ROW_W-1:0]        h_ext, qr;
    logic [COL_W-1:0]        qc;
    logic [PIXEL_BITS-1:0]   wr_pix;
    logic [2*PIXEL_BITS-1:0] wr_data;
    logic [2*PIXEL_BITS-1:0] r_rd;
    logic [PIXEL_BITS-1:0]   new_col [3];
    logic [PIXEL_BITS-1:0]   r_win [2][3];
    logic [2:0]              row_ok;
    logic                    left_ok, right_ok, hit;

    // Each entry holds the two rows above the current one at that column.
    logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];

    always_comb begin
        col_ext = WW'(r_col);
        col_inc = col_ext + WW'(1);
        h_ext   = ROW_W'(i_height);
        wr_pix  = (r_row < h_ext) ? i_pixel : '0;
        wr_data = {r_rd[PIXEL_BITS-1:0], wr_pix};

        new_col[0] = r_rd[2*PIXEL_BITS-1:PIXEL_BITS];
        new_col[1] = r_rd[PIXEL_BITS-1:0];
        new_col[2] = wr_pix;

        // At column 0 the window centre is the end of the row before last.
        if (r_col == '0) begin
            qr = r_row - ROW_W'(2);
            qc = COL_W'(i_width - WW'(1));
        end else begin
            qr = r_row - ROW_W'(1);
            qc = r_col - COL_W'(1);
        end

        row_ok[0] = (qr != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = ((qr + ROW_W'(1)) < h_ext);
        left_ok   = (qc != '0);
        right_ok  = (r_col != '0);

        hit = 1'b0;
        for (int k = 0; k < 3; k++) begin
            hit = hit | (row_ok[k] & ((left_ok & pix_hit(r_win[0][k], i_dilate))
                                      | pix_hit(r_win[1][k], i_dilate)
                                      | (right_ok & pix_hit(new_col[k], i_dilate))));
        end

        o_stat.at_origin = (r_row == '0) && (r_col == '0);
        o_stat.filling   = (r_row == '0) || ((r_row == ROW_W'(1)) && (r_col == '0));
        o_stat.drain     = (qr >= h_ext);
        o_stat.last      = (qr == h_ext - ROW_W'(1)) && (WW'(qc) == i_width - WW'(1));

        if (o_stat.drain) begin
            o_pixel = '0;
        end else if (hit) begin
            o_pixel = i_dilate ? PIX_MAX : '0;
        end else begin
            o_pixel = r_win[1][1];
        end

        n_row = r_row;
        n_col = r_col;
        if (i_clear) begin
            n_row = '0;
            n_col = '0;
        end else if (i_step) begin
            if (col_inc >= i_width) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_win[0] <= r_win[1];
            for (int k = 0; k < 3; k++) begin
                r_win[1][k] <= new_col[k];
            end
        end
    end

    // The read always targets the column of the next step; a write to that
    // same column in this cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            mem[r_col] <= wr_data;
        end
        if (i_step && (r_col == n_col)) begin
            r_rd <= wr_data;
        end else begin
            r_rd <= mem[n_col];
        end
    end

endmodule

`default_nettype wire

// File: design/binary_morphology_3x3_open_close.sv
// Top level of the streaming 3x3 binary morphology filter (erode, dilate, open/close chain).
// Depends on bmoc_pkg and instantiates four bmoc_stage line-buffer stages.
`default_nettype none

// Streaming 3x3 binary morphology on 8-bit pixels in raster order. The block
// takes one item per clock and, when the output side keeps up, never stalls:
// every accepted item steps all active stages in the same cycle, and any
// result it causes is registered in the output queue. Each stage
// delays the image by frame_width+1 items, so after the last pixel of a frame
// the source sends frame_width+1 flush items in erosion or dilation mode and
// 4*(frame_width+1) in chain mode; the last of them returns the frame_end
// result and rearms the block for the next frame. A flush item while the
// block sits at the start of a frame is dropped, and one inside a frame counts
// as a pixel of value 0. Each stage keeps two image rows in a line memory of
// MAX_WIDTH entries of two pixels, read ahead at the column of the next item
// and written back with the new pixel, so the sustained rate of one item per
// clock when the output side keeps up is set by that single read-modify-write
// per stage. Window edges are clipped to the image. A two-entry output queue
// lets the block take an item while one result waits; the input stalls only
// with both entries full. Configuration writes are always ready and restart
// the frame; the line memories need no clearing after reset.
module binary_morphology_3x3_open_close import bmoc_pkg::*; #(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // input channel
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [PIXEL_BITS-1:0]  i_pixel_in,
    input  wire                    i_is_flush,
    // output channel
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [PIXEL_BITS-1:0]  o_pixel_out,
    output logic                   o_frame_end,
    // configuration channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

    // Registers
    logic [WIDTH_REG_W-1:0] r_frame_width;
    logic [HEIGHT_W-1:0]    r_frame_height;
    logic [MODE_W-1:0]      r_op_mode;

    logic [WW-1:0]          eff_width;
    logic [HEIGHT_W-1:0]    eff_height;
    logic                   chain;
    logic                   cfg_wr;

    // Stage wiring
    logic [PIXEL_BITS-1:0]  stage_in  [NUM_STAGES];
    logic [PIXEL_BITS-1:0]  stage_out [NUM_STAGES];
    t_stage_stat            stat      [NUM_STAGES];
    logic [NUM_STAGES-1:0]  step;
    logic [NUM_STAGES-1:0]  dilate;

    logic                   accept, ignore, clear;
    logic                   res_push, res_last;
    logic [PIXEL_BITS-1:0]  res_pixel;
    t_stage_stat            out_stat;

    // Output queue: head register and one skid entry
    logic                   r_out_valid, n_out_valid;
    logic                   r_skid_valid, n_skid_valid;
    logic [PIXEL_BITS-1:0]  r_out_pixel, n_out_pixel, r_skid_pixel, n_skid_pixel;
    logic                   r_out_last, n_out_last, r_skid_last, n_skid_last;
    logic                   take;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_op_mode      <= RST_OP_MODE;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                CFG_OP_MODE:      r_op_mode      <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Width is clamped to 1..MAX_WIDTH and height to at least 1. Mode 3 runs
    // the chain like mode 2.
    always_comb begin
        if (r_frame_width == '0) begin
            eff_width = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = WW'(r_frame_width);
        end
        eff_height = (r_frame_height == '0) ? HEIGHT_W'(1) : r_frame_height;
        chain      = r_op_mode[1];
    end

    assign o_in_stall = r_skid_valid;
    assign accept     = i_in_valid && !o_in_stall;
    assign ignore     = i_is_flush && stat[0].at_origin;

    // A stage steps only when every stage before it has a window to emit;
    // a draining stage still passes a zero pixel on.
    always_comb begin
        step[0]     = accept && !ignore;
        stage_in[0] = i_is_flush ? '0 : i_pixel_in;
        for (int s = 1; s < NUM_STAGES; s++) begin
            step[s]     = step[s-1] && !stat[s-1].filling && chain;
            stage_in[s] = stage_out[s-1];
        end
        for (int s = 0; s < NUM_STAGES; s++) begin
            dilate[s] = chain ? ((s == 1) || (s == 2)) : (r_op_mode == MODE_DILATE);
        end
    end

    always_comb begin
        if (chain) begin
            out_stat  = stat[NUM_STAGES-1];
            res_pixel = stage_out[NUM_STAGES-1];
            res_push  = step[NUM_STAGES-1];
        end else begin
            out_stat  = stat[0];
            res_pixel = stage_out[0];
            res_push  = step[0];
        end
        res_push = res_push && !out_stat.filling && !out_stat.drain;
        res_last = out_stat.last;
        // The frame's last result and any register write restart all stages.
        clear    = cfg_wr || (res_push && res_last);
    end

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        bmoc_stage #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_clear  (clear),
            .i_step   (step[g]),
            .i_dilate (dilate[g]),
            .i_width  (eff_width),
            .i_height (eff_height),
            .i_pixel  (stage_in[g]),
            .o_pixel  (stage_out[g]),
            .o_stat   (stat[g])
        );
    end

    // Output queue. A new result is only pushed while the skid entry is free.
    always_comb begin
        take         = r_out_valid && !i_out_stall;
        n_out_valid  = r_out_valid;
        n_out_pixel  = r_out_pixel;
        n_out_last   = r_out_last;
        n_skid_valid = r_skid_valid;
        n_skid_pixel = r_skid_pixel;
        n_skid_last  = r_skid_last;
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_pixel  = r_skid_pixel;
                n_out_last   = r_skid_last;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = res_push;
                n_out_pixel = res_pixel;
                n_out_last  = res_last;
            end
        end else if (res_push) begin
            n_skid_valid = 1'b1;
            n_skid_pixel = res_pixel;
            n_skid_last  = res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pixel  <= n_out_pixel;
        r_out_last   <= n_out_last;
        r_skid_pixel <= n_skid_pixel;
        r_skid_last  <= n_skid_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_out_pixel;
    assign o_frame_end = r_out_last;

    // The skid entry is only ever filled behind a waiting head entry.
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty head");

    // A result never arrives while both queue entries are taken.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !r_skid_valid)
        else $error("result pushed into full output queue");

    // The frame's last result rearms the first stage at the frame start.
    a_frame_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res_last) |=> stat[0].at_origin)
        else $error("first stage not back at frame start after frame end");

endmodule

`default_nettype wire
